// ===== hw/rtl/mec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse element classifier package
// Shared widths, element codes and the item and result records.
// ----------------------------------------------------------------------------
package mec_pkg;

    localparam int TIME_W = 16;
    localparam int TOL_W  = 4;
    localparam int EL_W   = 3;

    localparam logic [EL_W-1:0] EL_DOT        = 3'd0;
    localparam logic [EL_W-1:0] EL_DASH       = 3'd1;
    localparam logic [EL_W-1:0] EL_BAD_PULSE  = 3'd2;
    localparam logic [EL_W-1:0] EL_CHAR_SPACE = 3'd3;
    localparam logic [EL_W-1:0] EL_WORD_SPACE = 3'd4;
    localparam logic [EL_W-1:0] EL_CAL_DONE   = 3'd5;

    typedef struct packed {
        logic              key_level;
        logic [TIME_W-1:0] time_stamp;
        logic              calibrate_req;
    } t_item;

    typedef struct packed {
        logic [EL_W-1:0]   element;
        logic [TIME_W-1:0] width;
        logic [TIME_W-1:0] dot_ticks;
    } t_result;

endpackage

// ===== hw/rtl/mec_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse element classifier input stage
// Holds one accepted sample until the classifier takes it.
// ----------------------------------------------------------------------------
module mec_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mec_pkg::t_item i_item,
    output logic           o_valid,
    output mec_pkg::t_item o_item,
    input  logic           i_take
);
    import mec_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== hw/rtl/mec_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse element classifier core
// Edge timing, dot calibration and element matching in one pass per sample.
// ----------------------------------------------------------------------------
module mec_classify (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [mec_pkg::TOL_W-1:0] i_cfg_data,
    input  logic                      i_fire,
    input  mec_pkg::t_item            i_item,
    output logic                      o_res_valid,
    output mec_pkg::t_result          o_res
);
    import mec_pkg::*;

    localparam logic [2:0] M_CAL_RISE   = 3'd0;
    localparam logic [2:0] M_CAL_FALL   = 3'd1;
    localparam logic [2:0] M_START_RISE = 3'd2;
    localparam logic [2:0] M_START_FALL = 3'd3;
    localparam logic [2:0] M_DEC_RISE   = 3'd4;
    localparam logic [2:0] M_DEC_FALL   = 3'd5;

    localparam int BND_W = TIME_W + 5;

    logic [TOL_W-1:0]  r_tol;
    logic [2:0]        r_mode, n_mode;
    logic              r_prev;
    logic [TIME_W-1:0] r_rise, n_rise;
    logic [TIME_W-1:0] r_fall, n_fall;
    logic [TIME_W-1:0] r_first, n_first;
    logic [TIME_W-1:0] r_dot, n_dot;

    logic                    rise, fall;
    logic [TIME_W-1:0]       w_pulse, w_gap;
    logic signed [BND_W-1:0] lo1, hi1, lo3, hi3, lo7, hi7;
    logic [29:0]             cal_a, cal_b;
    logic [TIME_W+1:0]       three_b;
    logic                    emit;
    logic [EL_W-1:0]         el;
    logic [TIME_W-1:0]       el_w;

    function automatic logic near(input logic [TIME_W-1:0] w,
                                  input logic signed [BND_W-1:0] lo,
                                  input logic signed [BND_W-1:0] hi);
        logic signed [BND_W-1:0] sw;
        sw = $signed({5'b0, w});
        return (sw >= lo) && (sw <= hi);
    endfunction

    assign rise    = (i_item.key_level != r_prev) && i_item.key_level;
    assign fall    = (i_item.key_level != r_prev) && !i_item.key_level;
    assign w_pulse = i_item.time_stamp - r_rise;
    assign w_gap   = i_item.time_stamp - r_fall;

    assign lo1 = $signed({5'b0, r_dot}) - $signed({{(BND_W-TOL_W){1'b0}}, r_tol});
    assign hi1 = $signed({5'b0, r_dot}) + $signed({{(BND_W-TOL_W){1'b0}}, r_tol});
    assign lo3 = lo1 + (lo1 <<< 1);
    assign hi3 = hi1 + (hi1 <<< 1);
    assign lo7 = (lo1 <<< 3) - lo1;
    assign hi7 = (hi1 <<< 3) - hi1;

    assign cal_a   = 30'(r_first) * 30'd10000;
    assign cal_b   = 30'(w_pulse) * 30'd3333;
    assign three_b = 18'(w_pulse) + (18'(w_pulse) << 1);

    always_comb begin
        n_mode  = r_mode;
        n_rise  = r_rise;
        n_fall  = r_fall;
        n_first = r_first;
        n_dot   = r_dot;
        emit    = 1'b0;
        el      = EL_DOT;
        el_w    = w_pulse;
        if (i_item.calibrate_req) begin
            if (r_mode >= M_START_RISE) begin
                n_mode = M_CAL_RISE;
            end
        end else begin
            case (r_mode)
                M_CAL_RISE: begin
                    if (rise) begin
                        n_rise = i_item.time_stamp;
                        n_mode = M_CAL_FALL;
                    end
                end
                M_CAL_FALL: begin
                    if (fall) begin
                        n_fall = i_item.time_stamp;
                        n_mode = M_CAL_RISE;
                        el     = EL_CAL_DONE;
                        if (r_first == '0) begin
                            n_first = w_pulse;
                        end else if (cal_a <= cal_b) begin
                            n_dot  = r_first;
                            n_mode = M_START_RISE;
                            emit   = 1'b1;
                        end else if ({2'b0, r_first} >= three_b) begin
                            n_dot  = w_pulse;
                            n_mode = M_START_RISE;
                            emit   = 1'b1;
                        end else begin
                            n_first = w_pulse;
                        end
                    end
                end
                M_START_RISE, M_DEC_RISE: begin
                    if (rise) begin
                        n_rise = i_item.time_stamp;
                        n_mode = (r_mode == M_DEC_RISE) ? M_DEC_FALL : M_START_FALL;
                        el_w   = w_gap;
                        if (w_gap != r_dot) begin
                            if (near(w_gap, lo3, hi3)) begin
                                n_mode = M_DEC_FALL;
                                el     = EL_CHAR_SPACE;
                                emit   = 1'b1;
                            end else if (near(w_gap, lo7, hi7)) begin
                                n_mode = M_DEC_FALL;
                                el     = EL_WORD_SPACE;
                                emit   = 1'b1;
                            end
                        end
                    end
                end
                M_START_FALL: begin
                    if (fall) begin
                        n_fall = i_item.time_stamp;
                        n_mode = M_START_RISE;
                    end
                end
                M_DEC_FALL: begin
                    if (fall) begin
                        n_fall = i_item.time_stamp;
                        n_mode = M_DEC_RISE;
                        emit   = 1'b1;
                        if (near(w_pulse, lo1, hi1)) begin
                            el = EL_DOT;
                        end else if (near(w_pulse, lo3, hi3)) begin
                            el = EL_DASH;
                        end else begin
                            el = EL_BAD_PULSE;
                        end
                    end
                end
                default: begin
                    n_mode = M_CAL_RISE;
                end
            endcase
        end
    end

    assign o_res_valid     = i_fire && emit;
    assign o_res.element   = el;
    assign o_res.width     = el_w;
    assign o_res.dot_ticks = n_dot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= TOL_W'(1);
            r_mode  <= M_CAL_RISE;
            r_prev  <= 1'b0;
            r_rise  <= '0;
            r_fall  <= '0;
            r_first <= '0;
            r_dot   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_data;
            end
            if (i_fire) begin
                r_mode  <= n_mode;
                r_prev  <= i_item.key_level;
                r_rise  <= n_rise;
                r_fall  <= n_fall;
                r_first <= n_first;
                r_dot   <= n_dot;
            end
        end
    end

endmodule

// ===== hw/rtl/mec_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse element classifier result register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module mec_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  mec_pkg::t_result i_res,
    output logic             o_space,
    output logic             o_valid,
    output mec_pkg::t_result o_res,
    input  logic             i_ready
);
    import mec_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== hw/rtl/morse_element_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse element classifier
// Times key edges, learns the dot length and reports dots, dashes, spaces, bad pulses and the end of calibration.
//
//   channel   handshake              payload
//   input     i_valid / o_ready      i_key_level, i_time_stamp, i_calibrate_req
//   result    o_valid / i_ready      o_element, o_width, o_dot_ticks
//   config    i_cfg_we               i_cfg_data (tolerance)
//
// One sample per cycle unless the result stalls; the core works on the input
// register and loads the result register, which drives o_valid.
// Synchronous active-low reset; tolerance resets to 1.
// A stalled result holds the core, and the input register then fills and
// drops o_ready.
// ----------------------------------------------------------------------------
module morse_element_classifier (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_key_level,
    input  logic [mec_pkg::TIME_W-1:0] i_time_stamp,
    input  logic                       i_calibrate_req,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [mec_pkg::EL_W-1:0]   o_element,
    output logic [mec_pkg::TIME_W-1:0] o_width,
    output logic [mec_pkg::TIME_W-1:0] o_dot_ticks,
    input  logic                       i_cfg_we,
    input  logic [mec_pkg::TOL_W-1:0]  i_cfg_data
);
    import mec_pkg::*;

    t_item   in_item, held_item;
    t_result core_res, out_res;
    logic    held_valid, out_space, fire, res_valid;

    assign in_item.key_level     = i_key_level;
    assign in_item.time_stamp    = i_time_stamp;
    assign in_item.calibrate_req = i_calibrate_req;
    assign fire                  = held_valid && out_space;

    mec_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .o_item  (held_item),
        .i_take  (fire)
    );

    mec_classify u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_item      (held_item),
        .o_res_valid (res_valid),
        .o_res       (core_res)
    );

    mec_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (core_res),
        .o_space (out_space),
        .o_valid (o_valid),
        .o_res   (out_res),
        .i_ready (i_ready)
    );

    assign o_element   = out_res.element;
    assign o_width     = out_res.width;
    assign o_dot_ticks = out_res.dot_ticks;

endmodule

// ===== hw/rtl/mec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse element classifier checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mec_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [mec_pkg::EL_W-1:0]   o_element,
    input logic [mec_pkg::TIME_W-1:0] o_width,
    input logic [mec_pkg::TIME_W-1:0] o_dot_ticks
);
    import mec_pkg::*;

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_element) && $stable(o_width)
            && $stable(o_dot_ticks))
        else $error("stalled result changed");

    a_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_element <= EL_CAL_DONE)
        else $error("element code out of range");

    a_dot_width : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_element == EL_DOT |->
            {1'b0, o_width} <= {1'b0, o_dot_ticks} + 17'd15)
        else $error("dot wider than dot length plus tolerance");

endmodule

bind morse_element_classifier mec_checker u_mec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_element   (o_element),
    .o_width     (o_width),
    .o_dot_ticks (o_dot_ticks)
);
